[design/hbsf_pkg.sv]
// Shared types and constants for the HDLC byte-stuffing framer.
// No dependencies; imported by every module of the block except hbsf_out_check.
package hbsf_pkg;

    localparam logic [7:0] FLAG_BYTE      = 8'h7e;
    localparam logic [7:0] ESC_BYTE       = 8'h7d;
    localparam logic [7:0] ESC_FLAG       = 8'h5e;
    localparam logic [7:0] ESC_ESC        = 8'h5d;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;
    localparam logic [7:0] PROTOCOL_RESET = 8'h42;

    localparam logic [6:0] HDR_FIRST = 7'd6;
    localparam logic [6:0] HDR_LAST  = 7'd9;
    localparam logic [6:0] HDR_END   = 7'd10;

    localparam int MAX_PAYLOAD_DEF = 28;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int LEN_W  = 6;
    localparam int STEP_W = 3;

    // One request from the front part to the back part.
    typedef struct packed {
        logic             is_open;   // opening flag, then data as the protocol byte
        logic [7:0]       data;      // protocol byte, or a byte to stuff
        logic             has_len;   // append the length byte
        logic [LEN_W-1:0] len;
        logic             has_trl;   // append two zero bytes and the closing flag
    } cmd_t;

endpackage

[design/hdlc_byte_stuffing_framer.sv]
// HDLC byte-stuffing framer top level: front part, request queue, back part.
// Depends on hbsf_pkg, hbsf_front, hbsf_queue, hbsf_back, hbsf_out_check.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    tdata[7:0] message_byte, tuser start_of_message
//   m_*      out  m_tvalid / m_tready    tdata[7:0] serial_byte, tlast last,
//                                        tuser end_of_frame
//   cfg_*    in   cfg_valid / cfg_ready  cfg_data[7:0] protocol_id
//
// Each accepted message byte that is kept becomes one request in the front part;
// dropped bytes make none. The back part sends one serial byte per cycle while
// m_tready allows, one to six per request; the output port sets the sustained rate.
// The queue (QUEUE_DEPTH requests) lets the front accept while the back drains.
// rst_n clears control state asynchronously; protocol_id returns to 0x42.
// A stall on m_tready holds the output byte; s_tready drops only on a full queue.
module hdlc_byte_stuffing_framer #(
    parameter int MAX_PAYLOAD = hbsf_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = hbsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] message_byte
    input  logic       s_tuser,   // [0] start_of_message
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,  // protocol_id
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] serial_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] end_of_frame
);
    import hbsf_pkg::*;

    cmd_t push_cmd, head_cmd;
    logic push, full, pop, head_valid;

    // Front: classify each message byte and track the frame position.
    hbsf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (full),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    // Queue: decouple the two sides.
    hbsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: expand requests into stuffed serial bytes.
    hbsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // Port-level check of the output channel.
    hbsf_out_check u_out_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[design/hbsf_front.sv]
// Front part: accepts message bytes, tracks the frame position and turns the
// start, header and payload bytes into requests for the back part. Depends on hbsf_pkg.
module hbsf_front #(
    parameter int MAX_PAYLOAD = hbsf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               q_full,
    output logic               q_push,
    output hbsf_pkg::cmd_t     q_cmd
);
    import hbsf_pkg::*;

    logic [6:0]       pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             done_reg, done_next;
    logic [7:0]       proto_reg;
    logic             accept;
    logic             in_hdr, in_pay;
    logic [LEN_W-1:0] len_sat;
    logic             trl;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign len_sat = (s_tdata > 8'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : s_tdata[LEN_W-1:0];
    assign in_hdr  = (pos_reg >= HDR_FIRST) && (pos_reg < HDR_END);
    assign in_pay  = (pos_reg >= HDR_END);

    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        done_next = done_reg;
        q_push    = 1'b0;
        q_cmd     = '0;
        trl       = 1'b0;
        if (accept)
        begin
            if (s_tuser)
            begin
                q_push        = 1'b1;
                q_cmd.is_open = 1'b1;
                q_cmd.data    = proto_reg;
                len_next      = len_sat;
                done_next     = 1'b0;
                pos_next      = 7'd1;
            end
            else if (!done_reg)
            begin
                if (in_hdr && pos_reg == HDR_LAST)
                begin
                    trl = (len_reg == '0);
                end
                else if (in_pay)
                begin
                    trl = ({1'b0, pos_reg} + 8'd1) >= ({1'b0, HDR_END} + {2'b00, len_reg});
                end
                q_push        = in_hdr || in_pay;
                q_cmd.data    = s_tdata;
                q_cmd.has_len = in_hdr && (pos_reg == HDR_LAST);
                q_cmd.len     = len_reg;
                q_cmd.has_trl = trl;
                if (trl)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            done_reg  <= 1'b1;
            proto_reg <= PROTOCOL_RESET;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            done_reg <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                proto_reg <= cfg_data;
            end
        end
    end

    // An open frame never sits at position zero.
    a_open_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> pos_reg != '0)
        else $error("open frame at position zero");

    // A push never meets a full queue.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    // The frame position stays below HDR_END + MAX_PAYLOAD while a frame is open.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> pos_reg < 7'(HDR_END + MAX_PAYLOAD))
        else $error("frame position ran past the payload");

endmodule

[design/hbsf_queue.sv]
// Short request queue between the front and back parts.
// Depends on hbsf_pkg for the request type.
module hbsf_queue #(
    parameter int DEPTH = hbsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hbsf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output hbsf_pkg::cmd_t head_cmd
);
    import hbsf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count above depth");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");

endmodule

[design/hbsf_back.sv]
// Back part: expands each queued request into one to six serial bytes and
// drives the registered output channel. Depends on hbsf_pkg.
module hbsf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  hbsf_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);
    import hbsf_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg, m_tuser_reg;

    logic              load;
    logic [STEP_W-1:0] nb, total, k;
    logic [7:0]        first_b, second_b, cur_b;
    logic              cur_eof, cur_last;

    // Lay out the request: data bytes, optional length, optional trailer.
    always_comb
    begin
        first_b  = head_cmd.data;
        second_b = ZERO_BYTE;
        nb       = STEP_W'(1);
        if (head_cmd.is_open)
        begin
            first_b  = FLAG_BYTE;
            second_b = head_cmd.data;
            nb       = STEP_W'(2);
        end
        else if (head_cmd.data == FLAG_BYTE)
        begin
            first_b  = ESC_BYTE;
            second_b = ESC_FLAG;
            nb       = STEP_W'(2);
        end
        else if (head_cmd.data == ESC_BYTE)
        begin
            first_b  = ESC_BYTE;
            second_b = ESC_ESC;
            nb       = STEP_W'(2);
        end
        total = nb + STEP_W'(head_cmd.has_len) + (head_cmd.has_trl ? STEP_W'(3) : '0);
        k     = step_reg - nb - STEP_W'(head_cmd.has_len);

        cur_eof = 1'b0;
        if (step_reg < nb)
        begin
            cur_b = (step_reg == '0) ? first_b : second_b;
        end
        else if (head_cmd.has_len && step_reg == nb)
        begin
            cur_b = {2'b00, head_cmd.len};
        end
        else if (k == STEP_W'(2))
        begin
            cur_b   = FLAG_BYTE;
            cur_eof = 1'b1;
        end
        else
        begin
            cur_b = ZERO_BYTE;
        end
        cur_last = (step_reg == total - 1'b1);
    end

    assign load = head_valid && (!m_tvalid_reg || m_tready);
    assign pop  = load && cur_last;

    always_comb
    begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (load)
        begin
            m_tvalid_next = 1'b1;
            step_next     = cur_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= cur_b;
            m_tlast_reg <= cur_last;
            m_tuser_reg <= cur_eof;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // The closing flag is always the last byte of its request.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("closing flag not marked last");

    // The step counter stays inside the head request.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> step_reg < total)
        else $error("step past end of request");

    // The step counter rests at zero while no request is queued.
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> step_reg == '0)
        else $error("step counter left mid-request");

endmodule

[design/hbsf_top_unused_guard.sv]
// Closing-flag and stall-hold checker on the output channel ports.
// No dependencies; sees the top level's output ports only.
module hbsf_out_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       m_tuser
);
    localparam logic [7:0] FLAG = 8'h7e;

    a_eof_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == FLAG) && m_tlast)
        else $error("closing marker on a non-flag byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

endmodule
